FILE: hdl/cstr_pkg.sv
`default_nettype none
package cstr_pkg;

    localparam int unsigned VERTEX_LIMIT = 32;
    localparam int unsigned VTX_W        = 5;
    localparam int unsigned CNT_W        = 6;
    localparam logic [CNT_W-1:0] REP_INVALID = 6'd32;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_SOLVE = 1'b1
    } action_t;

    typedef struct packed {
        logic             action;
        logic [VTX_W-1:0] row;
        logic [VTX_W-1:0] col;
        logic             edge_req;
    } in_item_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] component_rank;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic                    we;
        logic [VTX_W-1:0]        waddr;
        logic [VERTEX_LIMIT-1:0] wdata;
        logic [VTX_W-1:0]        raddr;
    } mem_req_t;

endpackage
`default_nettype wire

FILE: hdl/cstr_if.sv
`default_nettype none
interface cstr_in_if;
    logic               valid;
    logic               ready;
    cstr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cstr_out_if;
    logic                valid;
    logic                ready;
    cstr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/cstr_reach_mem.sv
`default_nettype none
module cstr_reach_mem (
    input  wire logic                                clk,
    input  wire cstr_pkg::mem_req_t                  req,
    output logic [cstr_pkg::VERTEX_LIMIT-1:0]        rd_data
);
    logic [cstr_pkg::VERTEX_LIMIT-1:0] mem [cstr_pkg::VERTEX_LIMIT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/closure_scc_topological_rank_unit.sv
// Channel   Dir  Payload
// in_ch     in   action, row, col, edge_req
// out_ch    out  vertex, component_rank, last
// cfg       in   cfg_we, cfg_data (number of boolean variables)
//
// Matrix write: read-modify-write of one row of the reach memory.
// Solve with V vertices: transitive closure of the reach memory, then class
// labeling, then ranking of the classes, then one result per vertex.
// The reach memory has one read port and one write port (one row read and one row write a cycle).
// in_ch.ready is high only while idle; out_ch stalls hold the sequencer.
// Reset: 16 variables, no classes; matrix contents undefined until written.
`default_nettype none
module closure_scc_topological_rank_unit #(
    parameter int unsigned MAX_VARIABLES = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_data,
    cstr_in_if.sink         in_ch,
    cstr_out_if.source      out_ch
);
    localparam int unsigned VL    = cstr_pkg::VERTEX_LIMIT;
    localparam int unsigned VW    = cstr_pkg::VTX_W;
    localparam int unsigned CW    = cstr_pkg::CNT_W;
    localparam int unsigned VMAXI = (2 * MAX_VARIABLES > VL) ? VL : 2 * MAX_VARIABLES;
    localparam logic [CW-1:0] VMAX  = CW'(VMAXI);
    localparam logic [CW-1:0] NMAX  = CW'(MAX_VARIABLES > VL ? VL : MAX_VARIABLES);

    typedef enum logic [3:0] {
        S_IDLE, S_WR_MOD, S_K_RD, S_K_LD, S_I_UP, S_L_RI, S_L_LI, S_L_J, S_L_LAB,
        S_R_START, S_R_K, S_R_KD, S_R_S, S_O_LOAD, S_O_SEND
    } state_t;

    state_t            state_reg;
    logic [4:0]        vc_reg;
    logic [CW-1:0]     v_reg;
    logic [VL-1:0]     mask_reg;
    logic [CW-1:0]     i_reg, j_reg, k_reg, r_reg, total_reg;
    logic [VW-1:0]     lowest_reg;
    logic [VW-1:0]     wr_row_reg, wr_col_reg;
    logic              wr_bit_reg;
    logic [VL-1:0]     rowk_reg, rowi_reg, reach_u_reg;
    logic [VW-1:0]     label_reg [VL];
    logic [CW-1:0]     rep_reg [VL];
    logic [VW-1:0]     rank_reg [VL];
    logic              out_valid_reg;
    cstr_pkg::out_item_t out_data_reg;

    cstr_pkg::mem_req_t mem_req;
    logic [VL-1:0]      mem_q;

    logic          in_fire, out_fire;
    logic [CW-1:0] n_eff, v_calc;
    logic [CW-1:0] i_inc, j_inc, k_inc, r_inc;
    logic [CW-1:0] rep_k, rep_j;

    cstr_reach_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_q)
    );

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_valid_reg && out_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign i_inc = i_reg + CW'(1);
    assign j_inc = j_reg + CW'(1);
    assign k_inc = k_reg + CW'(1);
    assign r_inc = r_reg + CW'(1);
    assign rep_k = rep_reg[k_reg[VW-1:0]];
    assign rep_j = rep_reg[j_reg[VW-1:0]];

    always_comb
    begin
        n_eff = CW'(vc_reg);
        if (n_eff == '0)
        begin
            n_eff = CW'(1);
        end
        else if (n_eff > NMAX)
        begin
            n_eff = NMAX;
        end
        v_calc = {n_eff[CW-2:0], 1'b0};
        if (v_calc > VMAX)
        begin
            v_calc = VMAX;
        end
    end

    always_comb
    begin
        mem_req       = '0;
        mem_req.waddr = i_reg[VW-1:0];
        mem_req.wdata = mem_q | rowk_reg;
        unique case (state_reg)
            S_IDLE:   mem_req.raddr = in_ch.data.row;
            S_WR_MOD:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_row_reg;
                mem_req.wdata = mem_q;
                mem_req.wdata[wr_col_reg] = wr_bit_reg;
            end
            S_K_RD:   mem_req.raddr = k_reg[VW-1:0];
            S_I_UP:
            begin
                mem_req.we    = mem_q[k_reg[VW-1:0]];
                mem_req.raddr = i_inc[VW-1:0];
            end
            S_L_RI:   mem_req.raddr = i_reg[VW-1:0];
            S_L_J:    mem_req.raddr = j_inc[VW-1:0];
            S_R_K:    mem_req.raddr = rep_k[VW-1:0];
            default:  mem_req.raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vc_reg        <= 5'd16;
            v_reg         <= '0;
            mask_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            r_reg         <= '0;
            total_reg     <= '0;
            lowest_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < VL; n++)
            begin
                label_reg[n] <= '0;
                rep_reg[n]   <= cstr_pkg::REP_INVALID;
                rank_reg[n]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                vc_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        wr_row_reg <= in_ch.data.row;
                        wr_col_reg <= in_ch.data.col;
                        wr_bit_reg <= in_ch.data.edge_req;
                        if (in_ch.data.action == cstr_pkg::ACT_SOLVE)
                        begin
                            v_reg     <= v_calc;
                            mask_reg  <= v_calc[CW-1] ? '1
                                         : ((VL'(1) << v_calc[VW-1:0]) - VL'(1));
                            k_reg     <= '0;
                            state_reg <= S_K_RD;
                        end
                        else
                        begin
                            state_reg <= S_WR_MOD;
                        end
                    end
                end
                S_WR_MOD: state_reg <= S_IDLE;
                S_K_RD:   state_reg <= S_K_LD;
                S_K_LD:
                begin
                    rowk_reg  <= mem_q & mask_reg;
                    i_reg     <= '0;
                    state_reg <= S_I_UP;
                end
                S_I_UP:
                begin
                    if (i_inc == v_reg)
                    begin
                        i_reg <= '0;
                        if (k_inc == v_reg)
                        begin
                            total_reg <= '0;
                            for (int n = 0; n < VL; n++)
                            begin
                                rep_reg[n] <= cstr_pkg::REP_INVALID;
                            end
                            state_reg <= S_L_RI;
                        end
                        else
                        begin
                            k_reg     <= k_inc;
                            state_reg <= S_K_RD;
                        end
                    end
                    else
                    begin
                        i_reg <= i_inc;
                    end
                end
                S_L_RI:   state_reg <= S_L_LI;
                S_L_LI:
                begin
                    rowi_reg <= mem_q;
                    j_reg    <= '0;
                    if (i_reg == '0)
                    begin
                        lowest_reg <= '0;
                        state_reg  <= S_L_LAB;
                    end
                    else
                    begin
                        state_reg <= S_L_J;
                    end
                end
                S_L_J:
                begin
                    // mutual reachability between i and j
                    if (rowi_reg[j_reg[VW-1:0]] && mem_q[i_reg[VW-1:0]])
                    begin
                        lowest_reg <= j_reg[VW-1:0];
                        state_reg  <= S_L_LAB;
                    end
                    else if (j_inc == i_reg)
                    begin
                        lowest_reg <= i_reg[VW-1:0];
                        state_reg  <= S_L_LAB;
                    end
                    else
                    begin
                        j_reg <= j_inc;
                    end
                end
                S_L_LAB:
                begin
                    if (lowest_reg == i_reg[VW-1:0])
                    begin
                        rep_reg[total_reg[VW-1:0]] <= CW'(i_reg[VW-1:0]);
                        label_reg[i_reg[VW-1:0]]   <= total_reg[VW-1:0];
                        total_reg                  <= total_reg + CW'(1);
                    end
                    else
                    begin
                        label_reg[i_reg[VW-1:0]] <= label_reg[lowest_reg];
                    end
                    if (i_inc == v_reg)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_R_START;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_L_RI;
                    end
                end
                S_R_START:
                begin
                    reach_u_reg <= '0;
                    k_reg       <= '0;
                    state_reg   <= S_R_K;
                end
                S_R_K:
                begin
                    if (k_reg == total_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_R_S;
                    end
                    else if (rep_k != cstr_pkg::REP_INVALID)
                    begin
                        state_reg <= S_R_KD;
                    end
                    else
                    begin
                        k_reg <= k_inc;
                    end
                end
                S_R_KD:
                begin
                    // union of what other live classes reach, self edge dropped
                    reach_u_reg <= reach_u_reg | (mem_q & ~(VL'(1) << rep_k[VW-1:0]));
                    k_reg       <= k_inc;
                    state_reg   <= S_R_K;
                end
                S_R_S:
                begin
                    if ((j_reg == total_reg) || ((rep_j != cstr_pkg::REP_INVALID)
                        && !reach_u_reg[rep_j[VW-1:0]]))
                    begin
                        if (j_reg == total_reg)
                        begin
                            rank_reg[j_reg[VW-1:0] - VW'(1)] <= r_reg[VW-1:0];
                        end
                        else
                        begin
                            rank_reg[j_reg[VW-1:0]] <= r_reg[VW-1:0];
                            rep_reg[j_reg[VW-1:0]]  <= cstr_pkg::REP_INVALID;
                        end
                        if (r_inc == total_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_O_LOAD;
                        end
                        else
                        begin
                            r_reg     <= r_inc;
                            state_reg <= S_R_START;
                        end
                    end
                    else
                    begin
                        j_reg <= j_inc;
                    end
                end
                S_O_LOAD:
                begin
                    out_data_reg.vertex         <= i_reg[VW-1:0];
                    out_data_reg.component_rank <= rank_reg[label_reg[i_reg[VW-1:0]]];
                    out_data_reg.last           <= (i_inc == v_reg);
                    out_valid_reg               <= 1'b1;
                    state_reg                   <= S_O_SEND;
                end
                S_O_SEND:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_data_reg.last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_inc;
                            state_reg <= S_O_LOAD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("input ready while result pending");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_data_reg.last) |=> in_ch.ready) else $error("not idle after last");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(VL)) else $error("class count overflow");
    a_vertex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (CW'(out_data_reg.vertex) < v_reg))
        else $error("vertex beyond active count");
endmodule
`default_nettype wire

FILE: test/tb_closure_scc_topological_rank_unit.sv
`default_nettype none
module tb_closure_scc_topological_rank_unit;

    localparam int WATCHDOG_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_data;

    cstr_in_if  in_bus ();
    cstr_out_if out_bus ();

    closure_scc_topological_rank_unit #(.MAX_VARIABLES(16)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_bus),
        .out_ch   (out_bus)
    );

    // predictor state
    logic [31:0] reach_mat [32];
    logic [4:0]  label_of  [32];
    logic [4:0]  rank_of   [32];
    logic [4:0]  var_count;

    cstr_pkg::in_item_t  pending_items [$];
    cstr_pkg::out_item_t expected_ranks [$];

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_start;
    int hold_cnt;
    int mismatches;
    int solves_seen;
    int ranks_seen;
    int writes_seen;
    int quiet_cycles;
    int items_pushed;
    bit gen_written [32][32];
    logic [4:0] gen_vc;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int active_vertices(logic [4:0] vc);
        int n;
        n = vc;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return 2 * n;
    endfunction

    function automatic void predict_transfer(cstr_pkg::in_item_t it);
        int v;
        int i;
        int j;
        int k;
        int total;
        int chosen;
        bit reached;
        logic [31:0] mask;
        int lowest [32];
        int rep [32];
        cstr_pkg::out_item_t res;
        if (it.action == cstr_pkg::ACT_WRITE) begin
            reach_mat[it.row][it.col] = it.edge_req;
            return;
        end
        v = active_vertices(var_count);
        mask = (v >= 32) ? 32'hFFFF_FFFF : ((32'd1 << v) - 1);
        for (k = 0; k < v; k++)
            for (i = 0; i < v; i++)
                if (reach_mat[i][k])
                    reach_mat[i] = reach_mat[i] | (reach_mat[k] & mask);
        for (i = 0; i < v; i++) begin
            lowest[i] = i;
            for (j = 0; j < i; j++)
                if (reach_mat[i][j] && reach_mat[j][i]) begin
                    lowest[i] = j;
                    break;
                end
        end
        total = 0;
        for (i = 0; i < 32; i++) rep[i] = 32;
        for (i = 0; i < v; i++) begin
            if (lowest[i] == i) begin
                rep[total] = i;
                label_of[i] = total[4:0];
                total++;
            end else begin
                label_of[i] = label_of[lowest[i]];
            end
        end
        // repeatedly pick the lowest-numbered class nobody else still reaches
        for (i = 0; i < total; i++) begin
            chosen = total - 1;
            for (j = 0; j < total; j++) begin
                if (rep[j] == 32) continue;
                reached = 1'b0;
                for (k = 0; k < total && !reached; k++) begin
                    if (k == j || rep[k] == 32) continue;
                    if (reach_mat[rep[k]][rep[j]]) reached = 1'b1;
                end
                if (!reached) begin
                    rep[j] = 32;
                    chosen = j;
                    break;
                end
            end
            rank_of[chosen] = i[4:0];
        end
        for (i = 0; i < v; i++) begin
            res.vertex = i[4:0];
            res.component_rank = rank_of[label_of[i]];
            res.last = (i == v - 1);
            expected_ranks.push_back(res);
        end
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                predict_transfer(in_bus.data);
                if (in_bus.data.action == cstr_pkg::ACT_SOLVE) solves_seen++;
                else writes_seen++;
            end
            if ((!in_bus.valid || in_bus.ready) ) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data  <= pending_items.pop_front();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_ranks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected rank transfer: vertex %0d rank %0d last %0b",
                                 out_bus.data.vertex, out_bus.data.component_rank,
                                 out_bus.data.last);
                end else begin
                    cstr_pkg::out_item_t exp_r;
                    exp_r = expected_ranks.pop_front();
                    ranks_seen++;
                    if (exp_r.vertex !== out_bus.data.vertex
                        || exp_r.component_rank !== out_bus.data.component_rank
                        || exp_r.last !== out_bus.data.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("rank mismatch: exp v%0d r%0d l%0b got v%0d r%0d l%0b",
                                     exp_r.vertex, exp_r.component_rank, exp_r.last,
                                     out_bus.data.vertex, out_bus.data.component_rank,
                                     out_bus.data.last);
                    end
                end
            end
            if (hold_start) begin
                hold_start = 1'b0;
                hold_cnt = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_write(int r, int c, bit e);
        cstr_pkg::in_item_t it;
        it.action = cstr_pkg::ACT_WRITE;
        it.row = r[4:0];
        it.col = c[4:0];
        it.edge_req = e;
        gen_written[r][c] = 1'b1;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    // fills any never-written entry of the active square first
    task automatic push_solve();
        cstr_pkg::in_item_t it;
        int v;
        v = active_vertices(gen_vc);
        for (int r = 0; r < v; r++)
            for (int c = 0; c < v; c++)
                if (!gen_written[r][c]) push_write(r, c, ($urandom_range(5) == 0));
        it.action = cstr_pkg::ACT_SOLVE;
        it.row = 5'($urandom);
        it.col = 5'($urandom);
        it.edge_req = 1'($urandom);
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_bus.valid || expected_ranks.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_var_count(logic [4:0] vc);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= vc;
        @(posedge clk);
        cfg_we   <= 1'b0;
        var_count = vc;
        gen_vc = vc;
    endtask

    logic [4:0] phase_vc [8] = '{5'd1, 5'd3, 5'd0, 5'd6, 5'd2, 5'd4, 5'd5, 5'd7};

    initial begin
        int v;
        int n;
        int items_target;
        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        out_bus.ready = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = 5'd0;
        rst_n    = 1'b0;
        hold_start = 1'b0;
        hold_cnt = 0;
        mismatches = 0;
        solves_seen = 0;
        ranks_seen = 0;
        writes_seen = 0;
        quiet_cycles = 0;
        items_pushed = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        var_count = 5'd16;
        gen_vc = 5'd16;
        for (int r = 0; r < 32; r++) begin
            reach_mat[r] = '0;
            label_of[r] = '0;
            rank_of[r] = '0;
            for (int c = 0; c < 32; c++) gen_written[r][c] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: two vertices, cycle, repeat solve, off-square corner writes
        write_var_count(5'd1);
        push_write(0, 0, 1'b0); push_write(0, 1, 1'b0);
        push_write(1, 0, 1'b0); push_write(1, 1, 1'b0);
        push_solve();
        push_write(0, 1, 1'b1);
        push_solve();
        push_write(1, 0, 1'b1);
        push_solve();
        push_solve();
        push_write(31, 31, 1'b1);
        push_write(31, 0, 1'b0);
        push_write(0, 31, 1'b1);
        push_write(1, 1, 1'b1);
        push_solve();
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_var_count(phase_vc[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (p == 4) hold_start = 1'b1;
            v = active_vertices(gen_vc);
            items_target = 45;
            n = items_pushed;
            while (items_pushed - n < items_target) begin
                int burst;
                burst = (v >= 32) ? $urandom_range(1, 6) : $urandom_range(0, 12);
                for (int b = 0; b < burst; b++) begin
                    if ($urandom_range(9) == 0)
                        push_write($urandom_range(31), $urandom_range(31), 1'($urandom));
                    else
                        push_write($urandom_range(v - 1), $urandom_range(v - 1),
                                   ($urandom_range(3) == 0));
                end
                push_solve();
            end
            wait_drained();
        end

        $display("covered %0d matrix writes and %0d solves, %0d ranks checked",
                 writes_seen, solves_seen, ranks_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
